FILE: hdl/fffa_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package fffa_pkg;

    localparam int MAX_SEGMENTS    = 64;
    localparam int HEADER_BYTES    = 12;
    localparam int MIN_SPLIT_BYTES = 16;

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int BYTE_W = 21;
    localparam int OFF_W  = 20;
    localparam int ST_W   = 2;

    localparam logic [BYTE_W-1:0] HEAP_LIMIT = 21'd1048576;
    localparam logic [BYTE_W-1:0] HEAP_RESET = 21'd65536;
    localparam logic [BYTE_W-1:0] HDR        = BYTE_W'(HEADER_BYTES);
    localparam logic [BYTE_W-1:0] MIN_SPLIT  = BYTE_W'(MIN_SPLIT_BYTES);

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADOFF = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // read address selects
    localparam logic [1:0] RD_IDX    = 2'd0;
    localparam logic [1:0] RD_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_IDX_PD = 2'd2;
    localparam logic [1:0] RD_K_P1   = 2'd3;

    typedef struct packed {
        logic              used;
        logic [BYTE_W-1:0] size;
        logic [BYTE_W-1:0] start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic       init;
        logic       load;
        logic       rd;
        logic [1:0] rd_sel;
        logic       step;
        logic       take;
        logic       fail;
        logic       ares;
        logic       upwr;
        logic       awn;
        logic       awk;
        logic       rnres;
        logic       rnck;
        logic       rplan;
        logic       dnwr;
        logic       cnt_dec;
        logic       publish;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic hit;
        logic past_end;
        logic split;
        logic up_more;
        logic has_next;
        logic dn_more;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on fffa_pkg, fffa_ctrl, fffa_dp (and fffa_ram below it).
//
// The block keeps an address-ordered table of up to MAX_SEGMENTS heap
// segments in one RAM, each a header of HEADER_BYTES followed by a payload.
// One transaction at a time is worked on: an allocate scans the table for
// the first free segment that fits, and a split moves every later entry up
// one place. A release scans the same way for the matching payload offset,
// folds free neighbors into one entry and moves the later entries down.
// Entries are scanned and moved one at a time through the single RAM read
// port, and the entries scanned and moved together never exceed the table.
// After reset, and after each write of the heap size, the table is rebuilt
// while input is stalled. The result sits in an output register, so the next
// transaction is accepted while the previous result still waits to be taken.
`default_nettype none
module first_fit_heap_allocator_core
    import fffa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [BYTE_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_operation,
    input  wire logic [BYTE_W-1:0] i_request_bytes,
    input  wire logic [OFF_W-1:0]  i_release_offset,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [ST_W-1:0]        o_status,
    output logic [OFF_W-1:0]       o_payload_offset,
    output logic [BYTE_W-1:0]      o_granted_bytes
);
    t_cmd cmd;
    t_sts sts;

    // sequencer: owns the state, issues one datapath command set a cycle
    fffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath: table RAM, indexes, entry holding registers, result output
    fffa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset),
        .o_granted_bytes  (o_granted_bytes)
    );
endmodule
`default_nettype wire

FILE: hdl/fffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/fffa_ctrl.sv
// Sequencer for the allocator: search, shift and merge steps.
// Depends on fffa_pkg; drives the datapath through t_cmd, reads t_sts.
`default_nettype none
module fffa_ctrl
    import fffa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_cfg_we,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCK   = 4'd3;
    localparam logic [3:0] S_APLAN = 4'd4;
    localparam logic [3:0] S_UPCK  = 4'd5;
    localparam logic [3:0] S_UPWR  = 4'd6;
    localparam logic [3:0] S_AWN   = 4'd7;
    localparam logic [3:0] S_AWK   = 4'd8;
    localparam logic [3:0] S_RNRD  = 4'd9;
    localparam logic [3:0] S_RNCK  = 4'd10;
    localparam logic [3:0] S_RPLAN = 4'd11;
    localparam logic [3:0] S_DNCK  = 4'd12;
    localparam logic [3:0] S_DNWR  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && !i_cfg_we) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SRD;
                end
            end
            S_SRD: begin
                if (i_sts.past_end) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = RD_IDX;
                    n_state      = S_SCK;
                end
            end
            S_SCK: begin
                if (i_sts.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = (i_sts.op == OP_ALLOC) ? S_APLAN : S_RNRD;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SRD;
                end
            end
            S_APLAN: begin
                o_cmd.ares = 1'b1;
                n_state    = i_sts.split ? S_UPCK : S_AWK;
            end
            S_UPCK: begin
                if (i_sts.up_more) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state      = S_UPWR;
                end else begin
                    n_state = S_AWN;
                end
            end
            S_UPWR: begin
                o_cmd.upwr = 1'b1;
                n_state    = S_UPCK;
            end
            S_AWN: begin
                o_cmd.awn = 1'b1;
                n_state   = S_AWK;
            end
            S_AWK: begin
                o_cmd.awk = 1'b1;
                n_state   = S_DONE;
            end
            S_RNRD: begin
                o_cmd.rnres = 1'b1;
                if (i_sts.has_next) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = RD_K_P1;
                    n_state      = S_RNCK;
                end else begin
                    n_state = S_RPLAN;
                end
            end
            S_RNCK: begin
                o_cmd.rnck = 1'b1;
                n_state    = S_RPLAN;
            end
            S_RPLAN: begin
                o_cmd.rplan = 1'b1;
                n_state     = S_DNCK;
            end
            S_DNCK: begin
                if (i_sts.dn_more) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = RD_IDX_PD;
                    n_state      = S_DNWR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DNWR: begin
                o_cmd.dnwr = 1'b1;
                n_state    = S_DNCK;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/fffa_dp.sv
// Datapath: segment table RAM, scan and shift indexes, result registers.
// Depends on fffa_pkg and fffa_ram; commanded by fffa_ctrl.
`default_nettype none
module fffa_dp
    import fffa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [BYTE_W-1:0] i_cfg_data,
    input  wire logic              i_operation,
    input  wire logic [BYTE_W-1:0] i_request_bytes,
    input  wire logic [OFF_W-1:0]  i_release_offset,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic [ST_W-1:0]        o_status,
    output logic [OFF_W-1:0]       o_payload_offset,
    output logic [BYTE_W-1:0]      o_granted_bytes
);
    logic [BYTE_W-1:0] r_heap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_op;
    logic [BYTE_W-1:0] r_want;
    logic [OFF_W-1:0]  r_where;
    logic [IDX_W-1:0]  r_k;
    t_entry            r_cur, r_prev, r_nxt;
    logic              r_split, r_nfree;
    logic [1:0]        r_d;
    logic [ST_W-1:0]   r_res_status;
    logic [OFF_W-1:0]  r_res_off;
    logic [BYTE_W-1:0] r_res_bytes;
    logic              r_ovalid;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    t_entry            mem_wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    logic [BYTE_W-1:0] heap_total, size0, left, msize;
    logic [BYTE_W:0]   rel_sum;
    logic [CNT_W-1:0]  k_ext, k_p1, idx_m1, idx_pd, tgt_ext;
    logic [IDX_W-1:0]  tgt;
    logic              pfree, split;
    logic [1:0]        d;

    assign rdata = t_entry'(rdata_raw);

    assign heap_total = (r_heap > HEAP_LIMIT) ? HEAP_LIMIT :
                        ((r_heap < HDR) ? HDR : r_heap);
    assign size0   = heap_total - HDR;
    assign left    = r_cur.size - r_want;
    assign split   = (left > MIN_SPLIT) && (left >= HDR) &&
                     (r_count < CNT_W'(MAX_SEGMENTS));
    assign rel_sum = {1'b0, rdata.start} + {1'b0, HDR};
    assign k_ext   = {1'b0, r_k};
    assign k_p1    = k_ext + 1'b1;
    assign idx_m1  = r_idx - 1'b1;
    assign idx_pd  = r_idx + CNT_W'(r_d);
    assign pfree   = (r_k != '0) && !r_prev.used;
    assign d       = {1'b0, r_nfree} + {1'b0, pfree};
    assign tgt     = pfree ? (r_k - 1'b1) : r_k;
    assign tgt_ext = {1'b0, tgt} + 1'b1;
    assign msize   = r_cur.size
                   + (r_nfree ? (HDR + r_nxt.size) : '0)
                   + (pfree ? (r_prev.size + HDR) : '0);

    always_comb begin
        o_sts          = '0;
        o_sts.op       = r_op;
        o_sts.hit      = (r_op == OP_ALLOC) ? (!rdata.used && rdata.size >= r_want)
                                            : (rel_sum == (BYTE_W + 1)'(r_where));
        o_sts.past_end = r_idx >= r_count;
        o_sts.split    = split;
        o_sts.up_more  = r_idx > k_p1;
        o_sts.has_next = k_p1 < r_count;
        o_sts.dn_more  = (r_d != 2'd0) && (idx_pd < r_count);
        o_sts.out_busy = r_ovalid && i_out_stall;
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:    mem_raddr = r_idx[IDX_W-1:0];
            RD_IDX_M1: mem_raddr = idx_m1[IDX_W-1:0];
            RD_IDX_PD: mem_raddr = idx_pd[IDX_W-1:0];
            default:   mem_raddr = k_p1[IDX_W-1:0];
        endcase
    end

    always_comb begin
        mem_we    = 1'b1;
        mem_waddr = r_idx[IDX_W-1:0];
        mem_wdata = rdata;
        if (i_cmd.init) begin
            mem_waddr = '0;
            mem_wdata = '{used: 1'b0, size: size0, start: '0};
        end else if (i_cmd.awn) begin
            mem_waddr = k_p1[IDX_W-1:0];
            mem_wdata = '{used: 1'b0, size: left - HDR,
                          start: r_cur.start + HDR + r_want};
        end else if (i_cmd.awk) begin
            mem_waddr = r_k;
            mem_wdata = '{used: 1'b1, size: (r_split ? r_want : r_cur.size),
                          start: r_cur.start};
        end else if (i_cmd.rplan) begin
            mem_waddr = tgt;
            mem_wdata = '{used: 1'b0, size: msize,
                          start: (pfree ? r_prev.start : r_cur.start)};
        end else if (!(i_cmd.upwr || i_cmd.dnwr)) begin
            mem_we = 1'b0;
        end
    end

    fffa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata_raw)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap   <= HEAP_RESET;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap <= i_cfg_data;
            end
            if (i_cmd.init) begin
                r_count <= CNT_W'(1);
            end else if (i_cmd.awn) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(r_d);
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.step || i_cmd.dnwr) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.upwr) begin
                r_idx <= idx_m1;
            end else if (i_cmd.ares) begin
                r_idx <= r_count;
            end else if (i_cmd.rplan) begin
                r_idx <= tgt_ext;
            end
            if (i_cmd.publish) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_want  <= i_request_bytes;
            r_where <= i_release_offset;
        end
        if (i_cmd.step) begin
            r_prev <= rdata;
        end
        if (i_cmd.take) begin
            r_k   <= r_idx[IDX_W-1:0];
            r_cur <= rdata;
        end
        if (i_cmd.fail) begin
            r_res_status <= (r_op == OP_RELEASE) ? ST_BADOFF : ST_NOFIT;
            r_res_off    <= '0;
            r_res_bytes  <= '0;
        end
        if (i_cmd.ares) begin
            r_split      <= split;
            r_res_status <= ST_OK;
            r_res_off    <= OFF_W'(r_cur.start + HDR);
            r_res_bytes  <= split ? r_want : r_cur.size;
        end
        if (i_cmd.rnres) begin
            r_nfree      <= 1'b0;
            r_res_status <= ST_OK;
            r_res_off    <= r_where;
            r_res_bytes  <= r_cur.size;
        end
        if (i_cmd.rnck) begin
            r_nfree <= !rdata.used;
            r_nxt   <= rdata;
        end
        if (i_cmd.rplan) begin
            r_d <= d;
        end
        if (i_cmd.publish) begin
            o_status         <= r_res_status;
            o_payload_offset <= r_res_off;
            o_granted_bytes  <= r_res_bytes;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule
`default_nettype wire

FILE: hdl/fffa_chk.sv
// Port-level checker for the allocator core, bound to the top level.
// Depends on fffa_pkg.
`default_nettype none
module fffa_chk
    import fffa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [ST_W-1:0]   o_status,
    input wire logic [OFF_W-1:0]  o_payload_offset,
    input wire logic [BYTE_W-1:0] o_granted_bytes
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_payload_offset) && $stable(o_granted_bytes))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_NOFIT ||
                         o_status == ST_BADOFF))
        else $error("bad status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_payload_offset == '0 &&
            o_granted_bytes == '0)
        else $error("failed result carries data");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted a second transaction while busy");

    a_init_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input open before table rebuilt");
endmodule

bind first_fit_heap_allocator_core fffa_chk u_fffa_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_payload_offset (o_payload_offset),
    .o_granted_bytes  (o_granted_bytes)
);
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for first_fit_heap_allocator_core.
// Depends on fffa_pkg and the allocator RTL; predicts every transaction itself.
`default_nettype none
module testbench;
    import fffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 4 * MAX_SEGMENTS + 40;
    localparam int LONG_HOLD      = 600;
    localparam int RANDOM_ITEMS   = 1325;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [OFF_W-1:0]  offset;
        logic [BYTE_W-1:0] bytes;
    } t_grant;

    // One directed row: the grant is typed in only where chk is set.
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] bytes;
        logic [OFF_W-1:0]  offset;
        logic              chk;
        t_grant            grant;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [BYTE_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_operation = OP_ALLOC;
    logic [BYTE_W-1:0] i_request_bytes = '0;
    logic [OFF_W-1:0]  i_release_offset = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b1;
    logic [ST_W-1:0]   o_status;
    logic [OFF_W-1:0]  o_payload_offset;
    logic [BYTE_W-1:0] o_granted_bytes;

    first_fit_heap_allocator_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset),
        .o_granted_bytes  (o_granted_bytes)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the segment table, kept in address order.
    int unsigned seg_start [MAX_SEGMENTS];
    int unsigned seg_size  [MAX_SEGMENTS];
    bit          seg_used  [MAX_SEGMENTS];
    int unsigned seg_count;

    t_grant grant_q[$];      // grants still owed by the block, oldest first
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     tx_quiet = 1'b0; // sender runs back to back while set
    bit     rx_quiet = 1'b0; // receiver never stalls while set
    int     rx_taken = 0;

    // Rebuild the table as one free segment; clamp the heap size first.
    function automatic void rebuild_heap(logic [BYTE_W-1:0] heap);
        int unsigned total;
        total = {11'd0, heap};
        if (total > {11'd0, HEAP_LIMIT}) total = {11'd0, HEAP_LIMIT};
        if (total < HEADER_BYTES) total = HEADER_BYTES;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            seg_start[i] = 0;
            seg_size[i]  = 0;
            seg_used[i]  = 1'b0;
        end
        seg_size[0] = total - HEADER_BYTES;
        seg_count   = 1;
    endfunction

    // Absorb entry k into entry k-1 and close the gap.
    function automatic void merge_down(int unsigned k);
        seg_size[k-1] += HEADER_BYTES + seg_size[k];
        for (int unsigned i = k; i + 1 < seg_count; i++) begin
            seg_start[i] = seg_start[i+1];
            seg_size[i]  = seg_size[i+1];
            seg_used[i]  = seg_used[i+1];
        end
        seg_count--;
        seg_start[seg_count] = 0;
        seg_size[seg_count]  = 0;
        seg_used[seg_count]  = 1'b0;
    endfunction

    function automatic t_grant predict_alloc(int unsigned want);
        t_grant      g;
        int unsigned k;
        int unsigned left;
        g = '0;
        for (k = 0; k < seg_count; k++)
            if (!seg_used[k] && seg_size[k] >= want) break;
        if (k >= seg_count) begin
            g.status = ST_NOFIT;
            return g;
        end
        left = seg_size[k] - want;
        // Split only when the rest is worth a segment and the table has room.
        if (left > MIN_SPLIT_BYTES && left >= HEADER_BYTES && seg_count < MAX_SEGMENTS) begin
            for (int unsigned i = seg_count; i > k + 1; i--) begin
                seg_start[i] = seg_start[i-1];
                seg_size[i]  = seg_size[i-1];
                seg_used[i]  = seg_used[i-1];
            end
            seg_start[k+1] = seg_start[k] + HEADER_BYTES + want;
            seg_size[k+1]  = left - HEADER_BYTES;
            seg_used[k+1]  = 1'b0;
            seg_size[k]    = want;
            seg_count++;
        end
        seg_used[k] = 1'b1;
        g.status = ST_OK;
        g.offset = OFF_W'(seg_start[k] + HEADER_BYTES);
        g.bytes  = BYTE_W'(seg_size[k]);
        return g;
    endfunction

    function automatic t_grant predict_release(int unsigned where);
        t_grant      g;
        int unsigned k;
        g = '0;
        for (k = 0; k < seg_count; k++)
            if (seg_start[k] + HEADER_BYTES == where) break;
        if (k >= seg_count) begin
            g.status = ST_BADOFF;
            return g;
        end
        g.status = ST_OK;
        g.offset = OFF_W'(where);
        g.bytes  = BYTE_W'(seg_size[k]);
        seg_used[k] = 1'b0;
        if (k + 1 < seg_count && !seg_used[k+1]) merge_down(k + 1);
        if (k > 0 && !seg_used[k-1]) merge_down(k);
        return g;
    endfunction

    // Offer one transaction, hold it until accepted, then record its grant.
    // Valid stays high between back-to-back transactions.
    task automatic offer(input logic op, input logic [BYTE_W-1:0] bytes,
                         input logic [OFF_W-1:0] offset, input logic chk,
                         input t_grant typed);
        int     gap;
        t_grant g;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_request_bytes  <= bytes;
        i_release_offset <= offset;
        do @(posedge i_clk); while (o_in_stall);
        g = (op == OP_ALLOC) ? predict_alloc({11'd0, bytes})
                             : predict_release({12'd0, offset});
        // A typed row must agree with the shadow table; a slip here is a bench bug.
        if (chk && g !== typed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees with prediction: typed %h predicted %h",
                         typed, g);
        end
        grant_q.push_back(chk ? typed : g);
    endtask

    // Write the heap size once the block is idle.
    task automatic set_heap(input logic [BYTE_W-1:0] heap);
        i_in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= heap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rebuild_heap(heap);
    endtask

    // Draw one well-formed transaction most of the time, noise otherwise.
    task automatic random_item(input int alloc_pct);
        int unsigned pick;
        int unsigned used_idx[$];
        logic [BYTE_W-1:0] want;
        logic [OFF_W-1:0]  where;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      want = BYTE_W'($urandom_range(0, 64));
            else if (pick < 85) want = BYTE_W'($urandom_range(0, 4096));
            else if (pick < 95) want = BYTE_W'($urandom_range(0, seg_size[0] + 64));
            else                want = BYTE_W'($urandom());
            offer(OP_ALLOC, want, OFF_W'($urandom()), 1'b0, '0);
        end else begin
            for (int unsigned i = 0; i < seg_count; i++)
                if (seg_used[i]) used_idx.push_back(i);
            pick = $urandom_range(0, 99);
            if (pick < 70 && used_idx.size() != 0)
                where = OFF_W'(seg_start[used_idx[$urandom_range(0, used_idx.size()-1)]]
                               + HEADER_BYTES);
            else if (pick < 82)
                where = OFF_W'(seg_start[$urandom_range(0, seg_count-1)] + HEADER_BYTES);
            else
                where = OFF_W'($urandom());
            offer(OP_RELEASE, BYTE_W'($urandom()), where, 1'b0, '0);
        end
    endtask

    // Directed rows, all from the reset heap of 65536 bytes.
    t_row directed [] = '{
        // zero-byte allocate at the first payload
        '{OP_ALLOC,   21'd0,       20'd0,       1'b1, '{ST_OK,     20'd12, 21'd0}},
        // requests larger than any heap
        '{OP_ALLOC,   21'h1FFFFF,  20'hFFFFF,   1'b1, '{ST_NOFIT,  20'd0,  21'd0}},
        '{OP_ALLOC,   21'd1048576, 20'd0,       1'b1, '{ST_NOFIT,  20'd0,  21'd0}},
        // unknown offsets, zero included
        '{OP_RELEASE, 21'h1FFFFF,  20'd0,       1'b1, '{ST_BADOFF, 20'd0,  21'd0}},
        '{OP_RELEASE, 21'd0,       20'hFFFFF,   1'b1, '{ST_BADOFF, 20'd0,  21'd0}},
        '{OP_RELEASE, 21'd0,       20'd13,      1'b1, '{ST_BADOFF, 20'd0,  21'd0}},
        '{OP_ALLOC,   21'd100,     20'd0,       1'b1, '{ST_OK,     20'd24, 21'd100}},
        '{OP_ALLOC,   21'd3,       20'd0,       1'b0, '0},
        '{OP_ALLOC,   21'd40,      20'd0,       1'b0, '0},
        // release a used segment, then the same one again while free
        '{OP_RELEASE, 21'd0,       20'd24,      1'b1, '{ST_OK,     20'd24, 21'd100}},
        '{OP_RELEASE, 21'd0,       20'd24,      1'b1, '{ST_OK,     20'd24, 21'd100}},
        // refill the hole with a small remainder left over, then a zero-byte allocate
        '{OP_ALLOC,   21'd90,      20'd0,       1'b0, '0},
        '{OP_ALLOC,   21'd0,       20'd0,       1'b0, '0},
        '{OP_RELEASE, 21'd0,       20'd12,      1'b0, '0},
        '{OP_RELEASE, 21'd0,       20'd139,     1'b0, '0},
        '{OP_ALLOC,   21'd64000,   20'd0,       1'b0, '0},
        '{OP_ALLOC,   21'd65535,   20'd0,       1'b0, '0},
        // free the early segments in turn so each merges with the free one below it
        '{OP_RELEASE, 21'd0,       20'd24,      1'b0, '0},
        '{OP_RELEASE, 21'd0,       20'd136,     1'b0, '0},
        '{OP_RELEASE, 21'd0,       20'd151,     1'b0, '0},
        '{OP_RELEASE, 21'd0,       20'd203,     1'b0, '0},
        '{OP_ALLOC,   21'd65524,   20'd0,       1'b0, '0},
        '{OP_RELEASE, 21'd0,       20'd12,      1'b0, '0},
        '{OP_ALLOC,   21'd65524,   20'd0,       1'b0, '0},
        '{OP_RELEASE, 21'd0,       20'd12,      1'b0, '0}
    };

    // Heap sizes per phase and the share of allocates: the reset size first,
    // then a tiny heap of 16, zero (clamped), the largest, all ones (clamped), and
    // a few small heaps; the large heap leans on allocates to fill the table.
    int unsigned phase_heap [7] = '{65536, 16, 0, 1048576, 2097151, 300, 4096};
    int          phase_pct  [7] = '{55, 60, 60, 85, 55, 60, 65};

    // Sender: directed table first, then the random phases.
    initial begin
        rebuild_heap(HEAP_RESET);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            offer(directed[i].op, directed[i].bytes, directed[i].offset,
                  directed[i].chk, directed[i].grant);
        for (int p = 0; p < 7; p++) begin
            if (p != 0) set_heap(BYTE_W'(phase_heap[p]));
            for (int n = 0; n < RANDOM_ITEMS / 7; n++) begin
                // Switch between bursty and back-to-back stretches now and then.
                if (n % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
                random_item(phase_pct[p]);
            end
        end
        i_in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: take results, compare field by field with the oldest grant.
    // Hold stall for a drawn number of cycles after each transaction, and once
    // for a long stretch so the output register and the input both back up.
    initial begin : receiver
        int     rx_hold;
        t_grant want;
        rx_hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                rx_taken++;
                if (grant_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d offset %0d bytes %0d",
                                 o_status, o_payload_offset, o_granted_bytes);
                end else begin
                    want = grant_q.pop_front();
                    if (o_status !== want.status || o_payload_offset !== want.offset ||
                        o_granted_bytes !== want.bytes) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.status, want.offset, want.bytes,
                                     o_status, o_payload_offset, o_granted_bytes);
                    end
                end
                if (rx_taken % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
                if (rx_taken == 40) rx_hold = LONG_HOLD;
                else rx_hold = rx_quiet ? 0 : $urandom_range(0, 18);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/fffa_pkg.sv
hdl/fffa_ram.sv
hdl/fffa_ctrl.sv
hdl/fffa_dp.sv
hdl/first_fit_heap_allocator_core.sv
hdl/fffa_chk.sv
tb/testbench.sv
